### src/msig_pkg.sv
package msig_pkg;

	localparam int PatternBytesMax = 16;
	localparam int LenW = 5;
	localparam int AddrW = 32;
	localparam int CfgDataW = 64;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CARE_MASK    = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_PATTERN_LEN  = 2'd3;

	typedef struct packed {
		logic [PatternBytesMax-1:0][7:0] pattern;
		logic [PatternBytesMax-1:0]      care;
		logic [LenW-1:0]                 length;
	} cfg_t;

	typedef struct packed {
		logic             scan_start;
		logic             section_start;
		logic             section_readable;
		logic [AddrW-1:0] byte_address;
		logic [7:0]       data_byte;
	} item_t;

	typedef struct packed {
		logic             match_now;
		logic [AddrW-1:0] match_address;
		logic             found;
	} res_t;

endpackage

### src/msig_cfg_regs.sv
module msig_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [msig_pkg::CfgIdxW-1:0]  wr_index,
	input  logic [msig_pkg::CfgDataW-1:0] wr_data,
	output msig_pkg::cfg_t                cfg
);
	import msig_pkg::*;

	logic [63:0]     pat_low_q;
	logic [63:0]     pat_high_q;
	logic [15:0]     care_q;
	logic [LenW-1:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= 16'hffff;
			len_q      <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_PATTERN_LOW:  pat_low_q  <= wr_data;
				REG_PATTERN_HIGH: pat_high_q <= wr_data;
				REG_CARE_MASK:    care_q     <= wr_data[15:0];
				REG_PATTERN_LEN:  len_q      <= wr_data[LenW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.pattern = {pat_high_q, pat_low_q};
	assign cfg.care    = care_q;
	assign cfg.length  = len_q;

endmodule

### src/msig_window.sv
module msig_window #(
	parameter int PATTERN_BYTES = msig_pkg::PatternBytesMax
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  msig_pkg::item_t item,
	input  msig_pkg::cfg_t  cfg,
	output msig_pkg::res_t  res
);
	import msig_pkg::*;

	localparam int IdxW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
	localparam int FillW = $clog2(PATTERN_BYTES + 1);
	localparam logic [LenW-1:0] Cap = LenW'(PATTERN_BYTES);

	logic [PATTERN_BYTES-1:0][7:0] win_q;
	logic [PATTERN_BYTES-1:0][7:0] win_n;
	logic [FillW-1:0]              fill_q;
	logic [FillW-1:0]              fill_clr;
	logic [FillW-1:0]              fill_n;
	logic                          found_q;
	logic                          found_keep;
	logic [LenW-1:0]               len_eff;
	logic                          all_eq;
	logic                          hit;

	assign len_eff = (cfg.length > Cap) ? Cap : cfg.length;

	// window after shift-in, newest at entry 0
	always_comb begin
		win_n = win_q;
		if (item.section_readable) begin
			for (int i = PATTERN_BYTES - 1; i > 0; i--) begin
				win_n[i] = win_q[i-1];
			end
			win_n[0] = item.data_byte;
		end
	end

	always_comb begin
		fill_clr = (item.scan_start || item.section_start) ? '0 : fill_q;
		fill_n = fill_clr;
		if (item.section_readable && (LenW'(fill_clr) < Cap)) begin
			fill_n = fill_clr + FillW'(1);
		end
	end

	assign found_keep = found_q && !item.scan_start;

	always_comb begin
		logic [LenW-1:0] pos;
		all_eq = 1'b1;
		for (int k = 0; k < PATTERN_BYTES; k++) begin
			pos = len_eff - LenW'(k) - LenW'(1);
			if ((LenW'(k) < len_eff) && cfg.care[k] &&
			    (win_n[pos[IdxW-1:0]] != cfg.pattern[k])) begin
				all_eq = 1'b0;
			end
		end
	end

	assign hit = item.section_readable && (len_eff != '0) &&
		(LenW'(fill_n) >= len_eff) && all_eq && !found_keep;

	assign res.match_now     = hit;
	assign res.match_address = hit ?
		(item.byte_address - AddrW'(len_eff) + AddrW'(1)) : '0;
	assign res.found         = found_keep || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			found_q <= 1'b0;
		end else if (step) begin
			fill_q  <= fill_n;
			found_q <= found_keep || hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			win_q <= win_n;
		end
	end

endmodule

### src/masked_byte_signature_scanner.sv
// masked byte signature scanner
//
// input channel: in_valid / in_stall with one image byte per item, its
// address and the scan_start, section_start and section_readable flags.
// output channel: out_valid / out_stall with one result per input item:
// match_now, match_address (start of the match, 0 otherwise) and found.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// pattern low word, pattern high word, care mask or pattern length.
// write config only while no items are in flight.
//
// an accepted item passes through the input register and the window compare into
// the result register, which drives out_valid; one item per cycle sustained
// while the output is not stalled.
// reset clears the window fill, the found flag and both valid bits; the care
// mask resets to all ones and the pattern length to zero (never matches).
// while out_stall is high with a valid result, the result register holds and
// one more item can sit in the input register before in_stall rises.
module masked_byte_signature_scanner #(
	parameter int PATTERN_BYTES = msig_pkg::PatternBytesMax
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          scan_start,
	input  logic                          section_start,
	input  logic                          section_readable,
	input  logic [msig_pkg::AddrW-1:0]    byte_address,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          match_now,
	output logic [msig_pkg::AddrW-1:0]    match_address,
	output logic                          found,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msig_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [msig_pkg::CfgDataW-1:0] cfg_data
);
	import msig_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_q;
	logic  out_valid_q;
	logic  out_load;
	logic  advance;
	logic  in_accept;

	assign cfg_ready = 1'b1;

	msig_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign out_load  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_load;
	assign in_stall  = valid_s1 && !out_load;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.scan_start       <= scan_start;
			item_s1.section_start    <= section_start;
			item_s1.section_readable <= section_readable;
			item_s1.byte_address     <= byte_address;
			item_s1.data_byte        <= data_byte;
		end
	end

	msig_window #(
		.PATTERN_BYTES (PATTERN_BYTES)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_now     = res_q.match_now;
	assign match_address = res_q.match_address;
	assign found         = res_q.found;

	a_match_sets_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_now |-> found)
		else $error("match without found flag");

	a_addr_zero_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !match_now |-> match_address == '0)
		else $error("match address nonzero without match");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipeline");

	a_no_lost_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register dropped an item");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import msig_pkg::*;

	localparam int ResultLatency = 2;
	localparam int QuietLimit = 3000;
	localparam int LongHold = 400;
	localparam int RandomPhases = 12;

	typedef enum bit {ROW_REG, ROW_BYTE} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [CfgIdxW-1:0]  reg_index;
		logic [CfgDataW-1:0] reg_value;
		item_t               it;
		bit                  typed;
		res_t                want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic scan_start = 1'b0;
	logic section_start = 1'b0;
	logic section_readable = 1'b0;
	logic [AddrW-1:0] byte_address = '0;
	logic [7:0] data_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic match_now;
	logic [AddrW-1:0] match_address;
	logic found;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	bit row_typed = 1'b0;
	res_t row_want = '0;

	stim_row_t stim_table[$];
	res_t results_due[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int calm_left = 0;
	int hold_row = -1;
	bit hold_request = 1'b0;
	bit held_long = 1'b0;

	logic [AddrW-1:0] gen_addr;
	bit gen_scan;
	bit gen_sect;
	int gen_count;

	cfg_t sig_cfg;
	logic [7:0] win_bytes[PatternBytesMax];
	int win_count;
	bit found_seen;

	masked_byte_signature_scanner dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.scan_start       (scan_start),
		.section_start    (section_start),
		.section_readable (section_readable),
		.byte_address     (byte_address),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.match_now        (match_now),
		.match_address    (match_address),
		.found            (found),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_t scan_byte(input item_t it);
		res_t r;
		int len;
		int i;
		int k;
		bit hit;
		r = '0;
		len = sig_cfg.length;
		if (len > PatternBytesMax) len = PatternBytesMax;
		if (it.scan_start) begin
			found_seen = 1'b0;
			win_count = 0;
		end
		if (it.section_start) win_count = 0;
		if (it.section_readable) begin
			for (i = PatternBytesMax - 1; i > 0; i--) win_bytes[i] = win_bytes[i - 1];
			win_bytes[0] = it.data_byte;
			if (win_count < PatternBytesMax) win_count++;
			hit = (len > 0) && (win_count >= len) && !found_seen;
			for (k = 0; k < len; k++) begin
				if (sig_cfg.care[k] && win_bytes[len - 1 - k] != sig_cfg.pattern[k]) hit = 1'b0;
			end
			if (hit) begin
				found_seen = 1'b1;
				r.match_now = 1'b1;
				r.match_address = it.byte_address - 32'(len - 1);
			end
		end
		r.found = found_seen;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 93) return $urandom_range(10, 40);
		calm_left = $urandom_range(20, 60);
		return 0;
	endfunction

	task automatic add_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
		stim_row_t row;
		row = '{ROW_REG, idx, value, '0, 1'b0, '0};
		stim_table.push_back(row);
	endtask

	task automatic add_checked(input bit s, input bit sec, input bit rd,
			input logic [AddrW-1:0] addr, input logic [7:0] value,
			input bit m, input logic [AddrW-1:0] maddr, input bit f);
		stim_row_t row;
		row = '{ROW_BYTE, '0, '0, {s, sec, rd, addr, value}, 1'b1, {m, maddr, f}};
		stim_table.push_back(row);
	endtask

	task automatic add_byte(input bit s, input bit sec, input bit rd,
			input logic [AddrW-1:0] addr, input logic [7:0] value);
		stim_row_t row;
		row = '{ROW_BYTE, '0, '0, {s, sec, rd, addr, value}, 1'b0, '0};
		stim_table.push_back(row);
	endtask

	task automatic emit(input bit rd, input logic [7:0] value);
		add_byte(gen_scan, gen_sect, rd, gen_addr, value);
		gen_scan = 1'b0;
		gen_sect = 1'b0;
		gen_addr = gen_addr + 1;
		if (rd) gen_count++;
	endtask

	task automatic build_directed();
		int i;
		// length zero right after reset
		add_checked(1, 1, 1, 32'h0000_0000, 8'h00, 0, 32'h0, 0);
		add_checked(0, 0, 1, 32'hFFFF_FFFF, 8'hFF, 0, 32'h0, 0);
		add_reg(REG_PATTERN_LOW, 64'h0000_0000_EFBE_ADDE);
		add_reg(REG_PATTERN_LEN, 64'd4);
		add_byte(1, 0, 1, 32'h1000, 8'hDE);
		add_byte(0, 0, 1, 32'h1001, 8'hAD);
		// unreadable byte inside the signature
		add_checked(0, 0, 0, 32'h1002, 8'h55, 0, 32'h0, 0);
		add_byte(0, 0, 1, 32'h1002, 8'hBE);
		add_checked(0, 0, 1, 32'h1003, 8'hEF, 1, 32'h1000, 1);
		add_reg(REG_PATTERN_LEN, 64'd1);
		add_checked(1, 0, 1, 32'h20, 8'hDE, 1, 32'h20, 1);
		add_checked(0, 0, 1, 32'h21, 8'hDE, 0, 32'h0, 1);
		add_checked(1, 0, 0, 32'h22, 8'hDE, 0, 32'h0, 0);
		// wildcard on byte one
		add_reg(REG_PATTERN_LEN, 64'd4);
		add_reg(REG_CARE_MASK, 64'hFFFD);
		add_byte(1, 0, 1, 32'h10, 8'hDE);
		add_byte(0, 0, 1, 32'h11, 8'h77);
		add_byte(0, 0, 1, 32'h12, 8'hBE);
		add_checked(0, 0, 1, 32'h13, 8'hEF, 1, 32'h10, 1);
		// section boundary splits the signature
		add_reg(REG_PATTERN_LEN, 64'd2);
		add_byte(1, 0, 1, 32'h30, 8'hDE);
		add_checked(0, 1, 1, 32'h31, 8'hAD, 0, 32'h0, 0);
		// length above capacity, all wildcards, address wraps
		add_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		add_reg(REG_CARE_MASK, 64'h0);
		add_reg(REG_PATTERN_LEN, 64'd31);
		for (i = 0; i < 15; i++)
			add_byte(i == 0, 0, 1, 32'hFFFF_FFF8 + i, i[0] ? 8'hFF : 8'h00);
		add_checked(0, 0, 1, 32'h0000_0007, 8'h5A, 1, 32'hFFFF_FFF8, 1);
	endtask

	task automatic build_random();
		int ph;
		int k;
		int eff;
		int quota;
		int r;
		int n;
		logic [63:0] pat_lo;
		logic [63:0] pat_hi;
		logic [127:0] pats;
		logic [15:0] care;
		logic [4:0] len;
		for (ph = 0; ph < RandomPhases; ph++) begin
			case (ph)
				0: begin
					pat_lo = '1;
					pat_hi = '1;
					care = 16'hFFFF;
					len = 5'd16;
				end
				1: begin
					pat_lo = '0;
					pat_hi = '0;
					care = 16'h0000;
					len = 5'd31;
				end
				2: begin
					pat_lo = {$urandom, $urandom};
					pat_hi = {$urandom, $urandom};
					care = 16'($urandom);
					len = 5'd0;
				end
				default: begin
					pat_lo = {$urandom, $urandom};
					pat_hi = {$urandom, $urandom};
					care = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
					len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(9, 20))
						: 5'($urandom_range(1, 8));
				end
			endcase
			pats = {pat_hi, pat_lo};
			add_reg(REG_PATTERN_LOW, pat_lo);
			add_reg(REG_PATTERN_HIGH, pat_hi);
			add_reg(REG_CARE_MASK, {48'h0, care});
			add_reg(REG_PATTERN_LEN, {59'h0, len});
			if (ph == 4) hold_row = stim_table.size();
			eff = (len > PatternBytesMax) ? PatternBytesMax : len;
			if (eff == 0) eff = 4;
			quota = (ph == 4) ? 150 : 52;
			gen_count = 0;
			gen_scan = 1'b1;
			gen_sect = 1'($urandom_range(0, 1));
			gen_addr = $urandom;
			while (gen_count < quota) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					for (k = 0; k < eff; k++) begin
						if ($urandom_range(0, 39) == 0) emit(1'b0, 8'($urandom));
						if ($urandom_range(0, 39) == 0) gen_sect = 1'b1;
						emit(1'b1, care[k] ? pats[8*k +: 8] : 8'($urandom));
					end
				end else if (r < 75) begin
					n = $urandom_range(1, 6);
					for (k = 0; k < n; k++) emit($urandom_range(0, 4) != 0, 8'($urandom));
				end else if (r < 85) begin
					gen_scan = 1'b1;
					gen_sect = 1'($urandom_range(0, 1));
				end else if (r < 92) begin
					gen_sect = 1'b1;
					if ($urandom_range(0, 1)) gen_addr = $urandom;
				end else if (r < 96) begin
					gen_addr = 32'hFFFF_FFFF - $urandom_range(0, 20);
				end else begin
					n = $urandom_range(1, eff);
					for (k = 0; k < n; k++) emit(1'b1, pats[8*k +: 8]);
				end
			end
		end
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (ResultLatency + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_PATTERN_LOW: sig_cfg.pattern[7:0] = value;
			REG_PATTERN_HIGH: sig_cfg.pattern[15:8] = value;
			REG_CARE_MASK: sig_cfg.care = value[15:0];
			REG_PATTERN_LEN: sig_cfg.length = value[LenW-1:0];
			default: ;
		endcase
	endtask

	task automatic send_byte(input stim_row_t row);
		in_valid <= 1'b1;
		scan_start <= row.it.scan_start;
		section_start <= row.it.section_start;
		section_readable <= row.it.section_readable;
		byte_address <= row.it.byte_address;
		data_byte <= row.it.data_byte;
		row_typed <= row.typed;
		row_want <= row.want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic run_rows();
		bit prev_reg;
		int gap;
		prev_reg = 1'b0;
		foreach (stim_table[n]) begin
			if (stim_table[n].kind == ROW_REG) begin
				if (!prev_reg) drain_block();
				write_reg(stim_table[n].reg_index, stim_table[n].reg_value);
				prev_reg = 1'b1;
			end else begin
				if (prev_reg) cfg_valid <= 1'b0;
				if (n == hold_row) hold_request = 1'b1;
				send_byte(stim_table[n]);
				prev_reg = 1'b0;
				gap = pick_gap();
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		drain_block();
	endtask

	task automatic note_mismatch(input string field, input logic [AddrW-1:0] want,
			input logic [AddrW-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %h, got %h", field, $realtime, want, got);
	endtask

	always @(posedge clk) begin
		item_t seen;
		res_t predicted;
		res_t want;
		res_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				seen = {scan_start, section_start, section_readable, byte_address, data_byte};
				predicted = scan_byte(seen);
				results_due.push_back(row_typed ? row_want : predicted);
			end
			if (out_valid && !out_stall) begin
				got = {match_now, match_address, found};
				if (results_due.size() == 0) begin
					note_mismatch("result with no item pending", '0, got.match_address);
				end else begin
					want = results_due.pop_front();
					if (got.match_now !== want.match_now)
						note_mismatch("match_now", AddrW'(want.match_now),
							AddrW'(got.match_now));
					if (got.match_address !== want.match_address)
						note_mismatch("match_address", want.match_address, got.match_address);
					if (got.found !== want.found)
						note_mismatch("found", AddrW'(want.found), AddrW'(got.found));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		bit level;
		int left;
		int r;
		level = 1'b0;
		left = 0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !held_long) begin
				held_long = 1'b1;
				level = 1'b1;
				left = LongHold;
			end else if (left <= 0) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					level = 1'b0;
					left = $urandom_range(1, 8);
				end else if (r < 88) begin
					level = 1'b1;
					left = $urandom_range(1, 3);
				end else if (r < 95) begin
					level = 1'b1;
					left = $urandom_range(15, 60);
				end else begin
					level = 1'b0;
					left = $urandom_range(30, 80);
				end
			end
			out_stall <= level;
			@(posedge clk);
			left--;
		end
	end

	initial begin
		sig_cfg.pattern = '0;
		sig_cfg.care = '1;
		sig_cfg.length = '0;
		foreach (win_bytes[i]) win_bytes[i] = 8'h00;
		win_count = 0;
		found_seen = 1'b0;
		build_directed();
		build_random();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		run_rows();
		if (results_due.size() != 0) mismatches++;
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
src/msig_pkg.sv
src/msig_cfg_regs.sv
src/msig_window.sv
src/masked_byte_signature_scanner.sv
verif/tb_top.sv
